// ----- rtl/core/rvenc_pkg.sv -----
package rvenc_pkg;

	localparam logic [6:0] OPC_OP       = 7'h33;
	localparam logic [6:0] OPC_OPIMM    = 7'h13;
	localparam logic [6:0] OPC_LOAD     = 7'h03;
	localparam logic [6:0] OPC_STORE    = 7'h23;
	localparam logic [6:0] OPC_BRANCH   = 7'h63;
	localparam logic [6:0] OPC_LUI      = 7'h37;
	localparam logic [6:0] OPC_AUIPC    = 7'h17;
	localparam logic [6:0] OPC_JAL      = 7'h6F;
	localparam logic [6:0] OPC_JALR     = 7'h67;
	localparam logic [6:0] OPC_SYSTEM   = 7'h73;
	localparam logic [6:0] OPC_MISC_MEM = 7'h0F;

	localparam logic [6:0]  F7_ALT     = 7'h20;
	localparam logic [11:0] IMM_ONES   = 12'hFFF;
	localparam logic [31:0] ROUND_HALF = 32'h0000_0800;
	localparam logic [4:0]  REG_RA     = 5'd1;

	typedef enum logic [5:0] {
		F_ADD = 6'd0, F_SUB, F_SLL, F_SLT, F_SLTU, F_XOR, F_SRL, F_SRA, F_OR, F_AND,
		F_ADDI, F_SLTI, F_SLTIU, F_XORI, F_ORI, F_ANDI, F_SLLI, F_SRLI, F_SRAI,
		F_LW, F_LH, F_LB, F_LHU, F_LBU, F_SW, F_SH, F_SB,
		F_BEQ, F_BNE, F_BLT, F_BGE, F_BLTU, F_BGEU, F_LUI, F_AUIPC,
		F_JAL, F_JALR, F_ECALL, F_EBREAK, F_FENCE,
		F_NOP, F_RET, F_MV, F_NOT, F_NEG, F_SEQZ, F_SNEZ,
		F_J, F_LI, F_LA, F_CALL,
		F_BEQZ, F_BNEZ, F_BLEZ, F_BGEZ, F_BLTZ, F_BGTZ
	} func_t;

	typedef enum logic [3:0] {
		RK_NONE = 4'd0, RK_LO12, RK_BRANCH, RK_HI20, RK_PCREL_HI20,
		RK_JAL, RK_LI, RK_LA, RK_CALL
	} reloc_t;

	typedef enum logic [3:0] {
		FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J, FMT_LI, FMT_PAIR, FMT_NONE
	} fmt_t;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_W    = 3'd2;
	localparam logic [2:0] F3_H    = 3'd1;
	localparam logic [2:0] F3_B    = 3'd0;
	localparam logic [2:0] F3_HU   = 3'd5;
	localparam logic [2:0] F3_BU   = 3'd4;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	typedef struct packed {
		fmt_t        fmt;
		logic [6:0]  opc;
		logic [6:0]  opc2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		reloc_t      reloc;
		logic        sym;
		logic        unk;
	} dec_t;

	typedef struct packed {
		logic [31:0] word0;
		logic [31:0] word1;
		logic        pair;
		reloc_t      reloc;
		logic        unk;
	} res_t;

	function automatic logic [31:0] pack_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] pack_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] pack_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [6:0] op);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
	endfunction

	function automatic logic [31:0] pack_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function automatic logic [31:0] pack_u(logic [19:0] upper, logic [4:0] rd, logic [6:0] op);
		return {upper, rd, op};
	endfunction

	function automatic logic [31:0] pack_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
	endfunction

endpackage

// ----- rtl/core/rv32i_instruction_encoder.sv -----
// RV32I encoder with pseudo-instructions. A transaction is taken when start is high and busy
// low; its first result word appears on the result ports, marked by strobe, after the decode,
// pack and output registers. Most mnemonics give one word, so a new transaction can be taken
// every cycle while busy is low. li with a wide immediate or a symbol, la and call give two
// words on consecutive cycles; while the second word is pending, busy is high for one cycle and
// the whole pipeline holds. The receiver cannot stall: every strobe cycle carries a result that
// must be taken.
module rv32i_instruction_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  func,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  src1_reg,
	input  logic [4:0]  src2_reg,
	input  logic signed [31:0] imm_value,
	input  logic        is_symbol,
	output logic        strobe,
	output logic [31:0] word,
	output logic        last,
	output logic [3:0]  reloc_kind,
	output logic        unknown_op
);

	logic               valid_s1, valid_s2, valid_s3;
	rvenc_pkg::dec_t    dec_d, dec_s1;
	logic [31:0]        li_sum_s1;
	rvenc_pkg::res_t    res_d, res_s2, res_s3;
	logic               second_q;
	logic               advance;
	logic [31:0]        imm_u, simm;

	// hold everything while the output stage still owes the second word of a pair
	assign busy    = valid_s3 & res_s3.pair & ~second_q;
	assign advance = ~busy;

	assign imm_u = imm_value;
	assign simm  = is_symbol ? 32'd0 : imm_u;

	// stage 1: decode into generic format fields
	always_comb begin
		dec_d       = '0;
		dec_d.fmt   = rvenc_pkg::FMT_NONE;
		dec_d.opc   = rvenc_pkg::OPC_OPIMM;
		dec_d.opc2  = rvenc_pkg::OPC_OPIMM;
		dec_d.f3    = rvenc_pkg::F3_ADD;
		dec_d.f7    = 7'd0;
		dec_d.rd    = dest_reg;
		dec_d.rs1   = src1_reg;
		dec_d.rs2   = src2_reg;
		dec_d.imm   = imm_u;
		dec_d.reloc = rvenc_pkg::RK_NONE;
		dec_d.sym   = is_symbol;
		dec_d.unk   = 1'b0;
		case (rvenc_pkg::func_t'(func))
			rvenc_pkg::F_ADD, rvenc_pkg::F_SUB, rvenc_pkg::F_SLL, rvenc_pkg::F_SLT,
			rvenc_pkg::F_SLTU, rvenc_pkg::F_XOR, rvenc_pkg::F_SRL, rvenc_pkg::F_SRA,
			rvenc_pkg::F_OR, rvenc_pkg::F_AND: begin
				dec_d.fmt = rvenc_pkg::FMT_R;
				dec_d.opc = rvenc_pkg::OPC_OP;
				case (rvenc_pkg::func_t'(func))
					rvenc_pkg::F_SUB: begin
						dec_d.f7 = rvenc_pkg::F7_ALT;
					end
					rvenc_pkg::F_SLL:  dec_d.f3 = rvenc_pkg::F3_SLL;
					rvenc_pkg::F_SLT:  dec_d.f3 = rvenc_pkg::F3_SLT;
					rvenc_pkg::F_SLTU: dec_d.f3 = rvenc_pkg::F3_SLTU;
					rvenc_pkg::F_XOR:  dec_d.f3 = rvenc_pkg::F3_XOR;
					rvenc_pkg::F_SRL:  dec_d.f3 = rvenc_pkg::F3_SR;
					rvenc_pkg::F_SRA: begin
						dec_d.f3 = rvenc_pkg::F3_SR;
						dec_d.f7 = rvenc_pkg::F7_ALT;
					end
					rvenc_pkg::F_OR:   dec_d.f3 = rvenc_pkg::F3_OR;
					rvenc_pkg::F_AND:  dec_d.f3 = rvenc_pkg::F3_AND;
					default:           dec_d.f3 = rvenc_pkg::F3_ADD;
				endcase
			end
			rvenc_pkg::F_ADDI: begin
				dec_d.fmt   = rvenc_pkg::FMT_I;
				dec_d.imm   = simm;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_LO12 : rvenc_pkg::RK_NONE;
			end
			rvenc_pkg::F_SLTI, rvenc_pkg::F_SLTIU, rvenc_pkg::F_XORI, rvenc_pkg::F_ORI,
			rvenc_pkg::F_ANDI: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				case (rvenc_pkg::func_t'(func))
					rvenc_pkg::F_SLTI:  dec_d.f3 = rvenc_pkg::F3_SLT;
					rvenc_pkg::F_SLTIU: dec_d.f3 = rvenc_pkg::F3_SLTU;
					rvenc_pkg::F_XORI:  dec_d.f3 = rvenc_pkg::F3_XOR;
					rvenc_pkg::F_ORI:   dec_d.f3 = rvenc_pkg::F3_OR;
					default:            dec_d.f3 = rvenc_pkg::F3_AND;
				endcase
			end
			rvenc_pkg::F_SLLI, rvenc_pkg::F_SRLI, rvenc_pkg::F_SRAI: begin
				// shift amount rides in the rs2 field
				dec_d.fmt = rvenc_pkg::FMT_R;
				dec_d.rs2 = imm_u[4:0];
				dec_d.f3  = (rvenc_pkg::func_t'(func) == rvenc_pkg::F_SLLI) ?
					rvenc_pkg::F3_SLL : rvenc_pkg::F3_SR;
				dec_d.f7  = (rvenc_pkg::func_t'(func) == rvenc_pkg::F_SRAI) ?
					rvenc_pkg::F7_ALT : 7'd0;
			end
			rvenc_pkg::F_LW, rvenc_pkg::F_LH, rvenc_pkg::F_LB, rvenc_pkg::F_LHU,
			rvenc_pkg::F_LBU: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.opc = rvenc_pkg::OPC_LOAD;
				case (rvenc_pkg::func_t'(func))
					rvenc_pkg::F_LW:  dec_d.f3 = rvenc_pkg::F3_W;
					rvenc_pkg::F_LH:  dec_d.f3 = rvenc_pkg::F3_H;
					rvenc_pkg::F_LB:  dec_d.f3 = rvenc_pkg::F3_B;
					rvenc_pkg::F_LHU: dec_d.f3 = rvenc_pkg::F3_HU;
					default:          dec_d.f3 = rvenc_pkg::F3_BU;
				endcase
			end
			rvenc_pkg::F_SW, rvenc_pkg::F_SH, rvenc_pkg::F_SB: begin
				dec_d.fmt = rvenc_pkg::FMT_S;
				dec_d.opc = rvenc_pkg::OPC_STORE;
				dec_d.rs2 = dest_reg;
				case (rvenc_pkg::func_t'(func))
					rvenc_pkg::F_SW: dec_d.f3 = rvenc_pkg::F3_W;
					rvenc_pkg::F_SH: dec_d.f3 = rvenc_pkg::F3_H;
					default:         dec_d.f3 = rvenc_pkg::F3_B;
				endcase
			end
			rvenc_pkg::F_BEQ, rvenc_pkg::F_BNE, rvenc_pkg::F_BLT, rvenc_pkg::F_BGE,
			rvenc_pkg::F_BLTU, rvenc_pkg::F_BGEU: begin
				dec_d.fmt   = rvenc_pkg::FMT_B;
				dec_d.imm   = simm;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_BRANCH : rvenc_pkg::RK_NONE;
				case (rvenc_pkg::func_t'(func))
					rvenc_pkg::F_BEQ:  dec_d.f3 = rvenc_pkg::F3_BEQ;
					rvenc_pkg::F_BNE:  dec_d.f3 = rvenc_pkg::F3_BNE;
					rvenc_pkg::F_BLT:  dec_d.f3 = rvenc_pkg::F3_BLT;
					rvenc_pkg::F_BGE:  dec_d.f3 = rvenc_pkg::F3_BGE;
					rvenc_pkg::F_BLTU: dec_d.f3 = rvenc_pkg::F3_BLTU;
					default:           dec_d.f3 = rvenc_pkg::F3_BGEU;
				endcase
			end
			rvenc_pkg::F_BEQZ, rvenc_pkg::F_BNEZ, rvenc_pkg::F_BGEZ, rvenc_pkg::F_BLTZ: begin
				dec_d.fmt   = rvenc_pkg::FMT_B;
				dec_d.imm   = simm;
				dec_d.rs2   = 5'd0;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_BRANCH : rvenc_pkg::RK_NONE;
				case (rvenc_pkg::func_t'(func))
					rvenc_pkg::F_BEQZ: dec_d.f3 = rvenc_pkg::F3_BEQ;
					rvenc_pkg::F_BNEZ: dec_d.f3 = rvenc_pkg::F3_BNE;
					rvenc_pkg::F_BGEZ: dec_d.f3 = rvenc_pkg::F3_BGE;
					default:           dec_d.f3 = rvenc_pkg::F3_BLT;
				endcase
			end
			rvenc_pkg::F_BLEZ, rvenc_pkg::F_BGTZ: begin
				// operands swapped against x0
				dec_d.fmt   = rvenc_pkg::FMT_B;
				dec_d.imm   = simm;
				dec_d.rs2   = src1_reg;
				dec_d.rs1   = 5'd0;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_BRANCH : rvenc_pkg::RK_NONE;
				dec_d.f3    = (rvenc_pkg::func_t'(func) == rvenc_pkg::F_BLEZ) ?
					rvenc_pkg::F3_BGE : rvenc_pkg::F3_BLT;
			end
			rvenc_pkg::F_LUI: begin
				dec_d.fmt   = rvenc_pkg::FMT_U;
				dec_d.opc   = rvenc_pkg::OPC_LUI;
				dec_d.imm   = simm;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_HI20 : rvenc_pkg::RK_NONE;
			end
			rvenc_pkg::F_AUIPC: begin
				dec_d.fmt   = rvenc_pkg::FMT_U;
				dec_d.opc   = rvenc_pkg::OPC_AUIPC;
				dec_d.imm   = simm;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_PCREL_HI20 : rvenc_pkg::RK_NONE;
			end
			rvenc_pkg::F_JAL, rvenc_pkg::F_J: begin
				dec_d.fmt   = rvenc_pkg::FMT_J;
				dec_d.imm   = simm;
				dec_d.rd    = (rvenc_pkg::func_t'(func) == rvenc_pkg::F_J) ? 5'd0 : dest_reg;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_JAL : rvenc_pkg::RK_NONE;
			end
			rvenc_pkg::F_JALR: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.opc = rvenc_pkg::OPC_JALR;
			end
			rvenc_pkg::F_ECALL, rvenc_pkg::F_EBREAK: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.opc = rvenc_pkg::OPC_SYSTEM;
				dec_d.rd  = 5'd0;
				dec_d.rs1 = 5'd0;
				dec_d.imm = (rvenc_pkg::func_t'(func) == rvenc_pkg::F_EBREAK) ? 32'd1 : 32'd0;
			end
			rvenc_pkg::F_FENCE, rvenc_pkg::F_NOP: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.opc = (rvenc_pkg::func_t'(func) == rvenc_pkg::F_FENCE) ?
					rvenc_pkg::OPC_MISC_MEM : rvenc_pkg::OPC_OPIMM;
				dec_d.rd  = 5'd0;
				dec_d.rs1 = 5'd0;
				dec_d.imm = 32'd0;
			end
			rvenc_pkg::F_RET: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.opc = rvenc_pkg::OPC_JALR;
				dec_d.rd  = 5'd0;
				dec_d.rs1 = rvenc_pkg::REG_RA;
				dec_d.imm = 32'd0;
			end
			rvenc_pkg::F_MV: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.imm = 32'd0;
			end
			rvenc_pkg::F_NOT: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.f3  = rvenc_pkg::F3_XOR;
				dec_d.imm = {20'd0, rvenc_pkg::IMM_ONES};
			end
			rvenc_pkg::F_SEQZ: begin
				dec_d.fmt = rvenc_pkg::FMT_I;
				dec_d.f3  = rvenc_pkg::F3_SLTU;
				dec_d.imm = 32'd1;
			end
			rvenc_pkg::F_NEG, rvenc_pkg::F_SNEZ: begin
				dec_d.fmt = rvenc_pkg::FMT_R;
				dec_d.opc = rvenc_pkg::OPC_OP;
				dec_d.rs2 = src1_reg;
				dec_d.rs1 = 5'd0;
				if (rvenc_pkg::func_t'(func) == rvenc_pkg::F_NEG) begin
					dec_d.f7 = rvenc_pkg::F7_ALT;
				end else begin
					dec_d.f3 = rvenc_pkg::F3_SLTU;
				end
			end
			rvenc_pkg::F_LI: begin
				dec_d.fmt   = rvenc_pkg::FMT_LI;
				dec_d.opc   = rvenc_pkg::OPC_LUI;
				dec_d.imm   = simm;
				dec_d.reloc = is_symbol ? rvenc_pkg::RK_LI : rvenc_pkg::RK_NONE;
			end
			rvenc_pkg::F_LA: begin
				dec_d.fmt   = rvenc_pkg::FMT_PAIR;
				dec_d.opc   = rvenc_pkg::OPC_AUIPC;
				dec_d.imm   = 32'd0;
				dec_d.reloc = rvenc_pkg::RK_LA;
			end
			rvenc_pkg::F_CALL: begin
				dec_d.fmt   = rvenc_pkg::FMT_PAIR;
				dec_d.opc   = rvenc_pkg::OPC_AUIPC;
				dec_d.opc2  = rvenc_pkg::OPC_JALR;
				dec_d.rd    = rvenc_pkg::REG_RA;
				dec_d.imm   = 32'd0;
				dec_d.reloc = rvenc_pkg::RK_CALL;
			end
			default: begin
				dec_d.fmt = rvenc_pkg::FMT_NONE;
				dec_d.unk = 1'b1;
			end
		endcase
	end

	// stage 2: li range check and field packing
	always_comb begin
		logic        li_pair;
		li_pair      = dec_s1.sym | (li_sum_s1[31:12] != 20'd0);
		res_d        = '0;
		res_d.reloc  = dec_s1.reloc;
		res_d.unk    = dec_s1.unk;
		case (dec_s1.fmt)
			rvenc_pkg::FMT_R: res_d.word0 = rvenc_pkg::pack_r(dec_s1.f7, dec_s1.rs2, dec_s1.rs1,
				dec_s1.f3, dec_s1.rd, dec_s1.opc);
			rvenc_pkg::FMT_I: res_d.word0 = rvenc_pkg::pack_i(dec_s1.imm[11:0], dec_s1.rs1,
				dec_s1.f3, dec_s1.rd, dec_s1.opc);
			rvenc_pkg::FMT_S: res_d.word0 = rvenc_pkg::pack_s(dec_s1.imm[11:0], dec_s1.rs2,
				dec_s1.rs1, dec_s1.f3, dec_s1.opc);
			rvenc_pkg::FMT_B: res_d.word0 = rvenc_pkg::pack_b(dec_s1.imm[12:0], dec_s1.rs2,
				dec_s1.rs1, dec_s1.f3);
			rvenc_pkg::FMT_U: res_d.word0 = rvenc_pkg::pack_u(dec_s1.imm[19:0], dec_s1.rd,
				dec_s1.opc);
			rvenc_pkg::FMT_J: res_d.word0 = rvenc_pkg::pack_j(dec_s1.imm[20:0], dec_s1.rd);
			rvenc_pkg::FMT_LI: begin
				// low 12 bits of imm are the addi part whether or not a lui is needed
				res_d.pair  = li_pair;
				res_d.word0 = li_pair ?
					rvenc_pkg::pack_u(li_sum_s1[31:12], dec_s1.rd, rvenc_pkg::OPC_LUI) :
					rvenc_pkg::pack_i(dec_s1.imm[11:0], 5'd0, rvenc_pkg::F3_ADD, dec_s1.rd,
						rvenc_pkg::OPC_OPIMM);
				res_d.word1 = rvenc_pkg::pack_i(dec_s1.imm[11:0], dec_s1.rd, rvenc_pkg::F3_ADD,
					dec_s1.rd, rvenc_pkg::OPC_OPIMM);
			end
			rvenc_pkg::FMT_PAIR: begin
				res_d.pair  = 1'b1;
				res_d.word0 = rvenc_pkg::pack_u(20'd0, dec_s1.rd, dec_s1.opc);
				res_d.word1 = rvenc_pkg::pack_i(12'd0, dec_s1.rd, rvenc_pkg::F3_ADD, dec_s1.rd,
					dec_s1.opc2);
			end
			default: res_d.word0 = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			second_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			second_q <= 1'b0;
		end else begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dec_s1    <= dec_d;
			li_sum_s1 <= simm + rvenc_pkg::ROUND_HALF;
			res_s2    <= res_d;
			res_s3    <= res_s2;
		end
	end

	assign strobe     = valid_s3;
	assign word       = second_q ? res_s3.word1 : res_s3.word0;
	assign last       = ~res_s3.pair | second_q;
	assign reloc_kind = second_q ? rvenc_pkg::RK_NONE : res_s3.reloc;
	assign unknown_op = res_s3.unk;

endmodule
